// ===== design/vfsr_pkg.sv =====
// vfsr_pkg: shared types and constants of the versioned flash slot registry
// holds op and status codes, stream word layouts, controller states and the
// command/status structs between controller and datapath; no dependencies
`default_nettype none

package vfsr_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 144;
  localparam int OP_W        = 2;
  localparam int ST_W        = 3;
  localparam int CFG_W       = 9;
  localparam int IDX_W       = 16;
  localparam int WORD_W      = 32;
  localparam int KIND_W      = 8;
  localparam int SLOT_OUT_W  = 8;
  localparam int CNT_OUT_W   = 9;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_ADD       = 2'd0,
    OP_FIND_ID   = 2'd1,
    OP_FIND_SLOT = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_STORED  = 3'd0,
    ST_STALE   = 3'd1,
    ST_RANGE   = 3'd2,
    ST_FOUND   = 3'd3,
    ST_MISSING = 3'd4
  } st_t;

  // input tdata, last listed field in the lowest bits
  typedef struct packed {
    logic [KIND_W-1:0] block_kind;
    logic [WORD_W-1:0] block_version;
    logic [WORD_W-1:0] block_id;
    logic [IDX_W-1:0]  slot_index;
  } in_word_t;

  // output tdata, last listed field in the lowest bits, zero padded to bytes
  typedef struct packed {
    logic [3:0]            pad;
    logic                  newest_valid;
    logic [WORD_W-1:0]     newest_version;
    logic [CNT_OUT_W-1:0]  free_count;
    logic                  free_found;
    logic [SLOT_OUT_W-1:0] next_free_slot;
    logic [KIND_W-1:0]     entry_kind;
    logic [WORD_W-1:0]     entry_version;
    logic [WORD_W-1:0]     entry_id;
    logic [SLOT_OUT_W-1:0] entry_slot;
    logic [SLOT_OUT_W-1:0] old_slot;
    logic                  had_old;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_IDSCAN,
    S_IDDONE,
    S_TGTCHK,
    S_WRTGT,
    S_SLOTCHK,
    S_MODINIT,
    S_MOD,
    S_FREEINIT,
    S_FREE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic set_st;
    st_t  st;
    logic scan_init;
    logic scan_free;
    logic scan_step;
    logic take_hit;
    logic ent_from_mem;
    logic rd_idx;
    logic commit;
    logic write_tgt;
    logic mod_init;
    logic mod_step;
    logic take_free;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic hit;
    logic scan_done;
    logic found;
    logic stale;
    logic rd_valid;
    logic mod_last;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/vfsr_ctrl.sv =====
// vfsr_ctrl: sequencer of the slot registry, one request at a time
// drives datapath commands from its status; uses vfsr_pkg
`default_nettype none

module vfsr_ctrl import vfsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_ADD:       state_next = sts.in_range ? S_IDSCAN : S_MODINIT;
          OP_FIND_ID:   state_next = S_IDSCAN;
          OP_FIND_SLOT: state_next = sts.in_range ? S_SLOTCHK : S_MODINIT;
          default:      state_next = S_MODINIT;
        endcase
      end
      S_IDSCAN: begin
        if (sts.hit || sts.scan_done) state_next = S_IDDONE;
      end
      S_IDDONE: begin
        if (sts.op == OP_ADD && !(sts.found && sts.stale)) state_next = S_TGTCHK;
        else state_next = S_MODINIT;
      end
      S_TGTCHK:   state_next = S_WRTGT;
      S_WRTGT:    state_next = S_MODINIT;
      S_SLOTCHK:  state_next = S_MODINIT;
      S_MODINIT:  state_next = S_MOD;
      S_MOD: begin
        if (sts.mod_last) state_next = S_FREEINIT;
      end
      S_FREEINIT: state_next = S_FREE;
      S_FREE: begin
        if (sts.hit || sts.scan_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.st   = ST_MISSING;
    s_tready = 1'b0;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_ADD: begin
            if (sts.in_range) begin
              cmd.scan_init = 1'b1;
            end else begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end
          end
          OP_FIND_ID: cmd.scan_init = 1'b1;
          OP_FIND_SLOT: begin
            if (sts.in_range) begin
              cmd.rd_idx = 1'b1;
            end else begin
              cmd.set_st = 1'b1;
              cmd.st     = ST_RANGE;
            end
          end
          default: cmd.set_st = 1'b1;
        endcase
      end
      S_IDSCAN: begin
        cmd.scan_step = 1'b1;
        cmd.take_hit  = sts.hit;
      end
      S_IDDONE: begin
        if (sts.op == OP_ADD) begin
          if (sts.found && sts.stale) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_STALE;
          end else begin
            cmd.rd_idx = 1'b1;
          end
        end else begin
          cmd.set_st = 1'b1;
          cmd.st     = sts.found ? ST_FOUND : ST_MISSING;
        end
      end
      S_TGTCHK: begin
        cmd.commit = 1'b1;
        cmd.set_st = 1'b1;
        cmd.st     = ST_STORED;
      end
      S_WRTGT: cmd.write_tgt = 1'b1;
      S_SLOTCHK: begin
        cmd.set_st       = 1'b1;
        cmd.st           = sts.rd_valid ? ST_FOUND : ST_MISSING;
        cmd.ent_from_mem = sts.rd_valid;
      end
      S_MODINIT: cmd.mod_init = 1'b1;
      S_MOD:     cmd.mod_step = 1'b1;
      S_FREEINIT: begin
        cmd.scan_init = 1'b1;
        cmd.scan_free = 1'b1;
      end
      S_FREE: begin
        cmd.scan_step = 1'b1;
        cmd.take_free = sts.hit;
      end
      S_OUT: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/vfsr_dp.sv =====
// vfsr_dp: datapath of the slot registry: slot memories, scan pipeline,
// remainder unit, registry state and the output register; uses vfsr_pkg
`default_nettype none

module vfsr_dp import vfsr_pkg::*; #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [OP_W-1:0]        s_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [ST_W-1:0]        m_tuser,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int CW1   = CW + 1;
  localparam int MW    = $clog2(SW + 1);
  localparam int ROW_W = 2 * WORD_W + KIND_W;

  in_word_t           in_word;
  logic [CFG_W-1:0]   slot_count;
  logic [CW-1:0]      n;

  op_t                in_op;
  logic [IDX_W-1:0]   in_idx;
  logic [WORD_W-1:0]  in_id;
  logic [WORD_W-1:0]  in_ver;
  logic [KIND_W-1:0]  in_kind;
  logic [SW-1:0]      idx;

  logic               vmem [MAX_SLOTS];
  logic [ROW_W-1:0]   dmem [MAX_SLOTS];
  logic               vwe;
  logic [SW-1:0]      vwaddr;
  logic               vwdata;
  logic [SW-1:0]      raddr;
  logic               vld_q;
  logic [ROW_W-1:0]   row_q;
  logic [SW-1:0]      rd_addr_q;
  logic [SW-1:0]      clr_ctr;

  logic [SW-1:0]      pos;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      lim;
  logic               mode_free;
  logic               pend_q;
  logic               issue;
  logic               hit;

  logic               found;
  logic [SW-1:0]      f_slot;
  logic               had_old;
  logic [SW-1:0]      ent_slot;
  logic [WORD_W-1:0]  ent_id;
  logic [WORD_W-1:0]  ent_ver;
  logic [KIND_W-1:0]  ent_kind;
  st_t                st;
  logic               evict;

  logic [WORD_W-1:0]  top_ver;
  logic               top_valid;
  logic [SW-1:0]      top_slot;
  logic [CW-1:0]      occ;

  logic [SW-1:0]      msh;
  logic [CW-1:0]      rem;
  logic [CW1-1:0]     rem_sh;
  logic [CW-1:0]      rem_next;
  logic [MW-1:0]      msteps;

  logic               free_found;
  logic [SW-1:0]      free_slot;
  logic               show;
  out_word_t          out_word;

  assign in_word = in_word_t'(s_tdata);

  // effective slot count: zero acts as one, clipped to the table depth
  always_comb begin
    if (slot_count == '0) begin
      n = CW'(1);
    end else if (32'(slot_count) > MAX_SLOTS) begin
      n = CW'(MAX_SLOTS);
    end else begin
      n = CW'(slot_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RESET;
    end else if (cfg_we) begin
      slot_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_op   <= op_t'(s_tuser);
      in_idx  <= in_word.slot_index;
      in_id   <= in_word.block_id;
      in_ver  <= in_word.block_version;
      in_kind <= in_word.block_kind;
    end
  end

  assign idx = SW'(in_idx);

  // slot memories, one shared read port with registered data
  always_comb begin
    vwe    = 1'b0;
    vwaddr = clr_ctr;
    vwdata = 1'b0;
    if (cmd.clr_step) begin
      vwe = 1'b1;
    end else if (cmd.commit && found) begin
      vwe    = 1'b1;
      vwaddr = f_slot;
    end else if (cmd.write_tgt) begin
      vwe    = 1'b1;
      vwaddr = idx;
      vwdata = 1'b1;
    end
  end

  assign raddr = cmd.rd_idx ? idx : pos;

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwaddr] <= vwdata;
    vld_q <= vmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_tgt) dmem[idx] <= {in_kind, in_ver, in_id};
    row_q     <= dmem[raddr];
    rd_addr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ctr <= '0;
    end else if (cmd.clr_step) begin
      clr_ctr <= clr_ctr + SW'(1);
    end
  end

  // scan pipeline: one address issued per cycle, checked in the cycle after its issue
  assign lim   = mode_free ? n : CW'(MAX_SLOTS);
  assign issue = cmd.scan_step && (cnt < lim);
  assign hit   = pend_q && (mode_free ? !vld_q
                                      : (vld_q && row_q[WORD_W-1:0] == in_id));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      pos       <= cmd.scan_free ? SW'(rem) : '0;
      cnt       <= '0;
      mode_free <= cmd.scan_free;
    end else if (issue) begin
      cnt <= cnt + CW'(1);
      pos <= (CW'(pos) + CW'(1) == lim) ? '0 : pos + SW'(1);
    end
  end

  // per-request result registers
  assign evict = vld_q && !(found && f_slot == idx);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      found   <= 1'b0;
      had_old <= 1'b0;
    end else if (cmd.take_hit) begin
      found  <= 1'b1;
      f_slot <= rd_addr_q;
    end else if (cmd.commit) begin
      had_old <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit || cmd.ent_from_mem) begin
      ent_slot <= rd_addr_q;
      ent_id   <= row_q[WORD_W-1:0];
      ent_ver  <= row_q[2*WORD_W-1:WORD_W];
      ent_kind <= row_q[ROW_W-1:2*WORD_W];
    end else if (cmd.commit) begin
      ent_slot <= idx;
      ent_id   <= in_id;
      ent_ver  <= in_ver;
      ent_kind <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_st) st <= cmd.st;
  end

  // registry state
  always_ff @(posedge clk) begin
    if (rst) begin
      top_ver   <= '0;
      top_valid <= 1'b0;
      top_slot  <= '0;
      occ       <= '0;
    end else if (cmd.commit) begin
      if (!top_valid || top_ver < in_ver) begin
        top_ver   <= in_ver;
        top_slot  <= idx;
        top_valid <= 1'b1;
      end
      occ <= occ + CW'(1) - CW'(found) - CW'(evict);
    end
  end

  // remainder of the newest slot by the count, one dividend bit a cycle
  assign rem_sh   = {rem, msh[SW-1]};
  assign rem_next = (rem_sh >= CW1'(n)) ? CW'(rem_sh - CW1'(n)) : CW'(rem_sh);

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      msh    <= top_valid ? top_slot : '0;
      rem    <= '0;
      msteps <= MW'(SW);
    end else if (cmd.mod_step) begin
      msh    <= msh << 1;
      rem    <= rem_next;
      msteps <= msteps - MW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init && cmd.scan_free) begin
      free_found <= 1'b0;
      free_slot  <= '0;
    end else if (cmd.take_free) begin
      free_found <= 1'b1;
      free_slot  <= rd_addr_q;
    end
  end

  // output register
  assign show = (st == ST_FOUND) || (st == ST_STORED);

  always_comb begin
    out_word                = '0;
    out_word.had_old        = had_old;
    out_word.old_slot       = had_old ? SLOT_OUT_W'(f_slot) : '0;
    out_word.entry_slot     = show ? SLOT_OUT_W'(ent_slot) : '0;
    out_word.entry_id       = show ? ent_id : '0;
    out_word.entry_version  = show ? ent_ver : '0;
    out_word.entry_kind     = show ? ent_kind : '0;
    out_word.next_free_slot = SLOT_OUT_W'(free_slot);
    out_word.free_found     = free_found;
    out_word.free_count     = (n > occ) ? CNT_OUT_W'(n - occ) : '0;
    out_word.newest_version = top_ver;
    out_word.newest_valid   = top_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= OUT_TDATA_W'(out_word);
      m_tuser <= st;
    end
  end

  always_comb begin
    sts.op        = in_op;
    sts.in_range  = in_idx < IDX_W'(n);
    sts.hit       = hit;
    sts.scan_done = !pend_q && (cnt == lim);
    sts.found     = found;
    sts.stale     = ent_ver >= in_ver;
    sts.rd_valid  = vld_q;
    sts.mod_last  = msteps == MW'(1);
    sts.out_free  = !m_tvalid || m_tready;
    sts.clr_last  = clr_ctr == SW'(MAX_SLOTS - 1);
  end

endmodule

`default_nettype wire

// ===== design/versioned_flash_slot_registry.sv =====
// versioned_flash_slot_registry: top level of the flash slot registry
// joins the sequencer vfsr_ctrl and the datapath vfsr_dp; uses vfsr_pkg
//
// usage
//   requests come in on the s_ stream: s_tuser carries the operation
//   (add, look up by id, look up by slot), s_tdata the slot index, id,
//   version and type code. every request gives exactly one result transfer
//   on the m_ stream: m_tuser is the status, m_tdata the entry fields,
//   next free slot, free count and newest version after the request.
//   the user must write slot_count through cfg_we/cfg_wdata only while the
//   block is idle; the block itself does not enforce this.
// timing
//   one request at a time; the id search and the free-slot search each walk
//   the single slot memory read port, a slot a cycle
// reset
//   rst clears the registry state and then a clearing pass over all MAX_SLOTS
//   slots marks every slot free; s_tready stays low during that pass.
// stalls
//   a finished result sits in the output register until taken; the next
//   request is already accepted meanwhile and only its own result waits.
`default_nettype none

module versioned_flash_slot_registry import vfsr_pkg::*; #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  // request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [15:0] slot_index, [47:16] block_id, [79:48] block_version,
  // [87:80] block_kind
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] operation
  input  logic [OP_W-1:0]        s_tuser,
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] had_old, [8:1] old_slot, [16:9] entry_slot, [48:17] entry_id,
  // [80:49] entry_version, [88:81] entry_kind, [96:89] next_free_slot,
  // [97] free_found, [106:98] free_count, [138:107] newest_version,
  // [139] newest_valid, [143:140] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // [2:0] status
  output logic [ST_W-1:0]        m_tuser,
  // slot_count register write
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  vfsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vfsr_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ===== design/vfsr_chk.sv =====
// vfsr_chk: port-level checks on the result stream of the slot registry
// bound to versioned_flash_slot_registry; uses vfsr_pkg
`default_nettype none

module vfsr_chk import vfsr_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [ST_W-1:0]        m_tuser
);

  out_word_t ow;
  assign ow = out_word_t'(m_tdata);

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // only a stored add can report a replaced version
  a_old_only_stored: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ow.had_old |-> m_tuser == ST_STORED)
    else $error("had_old outside a stored add");

  // no entry data unless stored or found
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_STORED && m_tuser != ST_FOUND |->
      ow.entry_id == '0 && ow.entry_version == '0 && ow.entry_kind == '0 &&
      ow.entry_slot == '0)
    else $error("entry fields set without an entry");

  // a stored block makes the newest version valid
  a_newest_after_store: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_STORED |-> ow.newest_valid)
    else $error("stored without newest_valid");

  // no free slot found means nothing left to count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !ow.free_found |-> ow.free_count == '0 && ow.next_free_slot == '0)
    else $error("free count without a free slot");

endmodule

bind versioned_flash_slot_registry vfsr_chk u_vfsr_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
